/* design/mbss_pkg.sv */
// Package: constants, types and helpers of the masked byte signature scan unit.
`default_nettype none

package mbss_pkg;

  // Signature window depth (positions past sixteen are always wildcards)
  localparam int PATTERN_BYTES = 16;
  localparam int WIN_IDX_W     = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 5;
  localparam int CARE_W  = 16;
  localparam int COUNT_W = 32;
  localparam int ADDR_W  = 64;

  // APB register map: 64-bit registers at 8-byte strides
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 3;
  localparam int APB_ADDR_W = REG_IDX_W + 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_BITS    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_REGION_BASE  = 3'd4
  } reg_idx_t;

  localparam logic [LEN_W-1:0]   PATTERN_LEN_RESET = LEN_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;

  typedef logic [BYTE_W-1:0] byte_t;

  // Signature byte p, taken from the two 64-bit pattern registers
  function automatic byte_t pattern_byte(input logic [63:0] lo, input logic [63:0] hi,
                                         input logic [3:0] p);
    logic [127:0] both;
    both = {hi, lo};
    return both[{p, 3'b000} +: BYTE_W];
  endfunction

endpackage

`default_nettype wire

/* design/mbss_in_if.sv */
// Interface: byte stream channel into the scan unit.
`default_nettype none

interface mbss_in_if;
  import mbss_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* design/mbss_out_if.sv */
// Interface: scan result channel out of the scan unit.
`default_nettype none

interface mbss_out_if;
  import mbss_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [ADDR_W-1:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink   (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

/* design/masked_byte_signature_scan_unit.sv */
// Top level: masked byte signature scan over a streamed memory region.
//
//  Channel     Dir  Handshake      Payload
//  byte_in     in   valid/ready    data_byte[7:0], last_byte
//  result_out  out  valid/ready    found, match_address[63:0]
//  APB         in   psel/penable   paddr[5:0], pwdata[63:0], prdata[63:0]
//
// One byte per cycle sustained; a held result stalls the input stage only
// when a new result is waiting. A byte is taken into the input stage; as
// the stage advances it is shifted into the window, the sixteen masked
// compares and address add decide the result, and the result register loads.
// Sync reset clears window, byte counter, report flag, registers (length to 1).
`default_nettype none

module masked_byte_signature_scan_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  mbss_in_if.sink                             byte_in,
  mbss_out_if.source                          result_out,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mbss_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [mbss_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [mbss_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);
  import mbss_pkg::*;

  // Configuration registers
  logic [63:0]        pattern_low;
  logic [63:0]        pattern_high;
  logic [CARE_W-1:0]  care_bits;
  logic [LEN_W-1:0]   pattern_length;
  logic [ADDR_W-1:0]  region_base;

  reg_idx_t reg_idx;
  logic     cfg_write;

  // Input stage
  logic  s_valid;
  byte_t s_data;
  logic  s_last;
  logic  stage_advance;

  // Scan state
  byte_t              window [PATTERN_BYTES];
  byte_t              win_new [PATTERN_BYTES];
  logic [COUNT_W-1:0] count;
  logic               reported;

  // Match logic
  logic [LEN_W-1:0]   len_eff;
  logic               win_match;
  logic               enough_seen;
  logic               can_check;
  logic               hit;
  logic               res_valid;
  logic [COUNT_W-1:0] start_off;
  logic [ADDR_W-1:0]  hit_addr;

  // Result register
  logic              out_valid;
  logic              out_found;
  logic [ADDR_W-1:0] out_addr;

  // ---------------- APB configuration port ----------------
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_bits      <= '0;
      pattern_length <= PATTERN_LEN_RESET;
      region_base    <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_PATTERN_LOW:  pattern_low    <= pwdata;
        REG_PATTERN_HIGH: pattern_high   <= pwdata;
        REG_CARE_BITS:    care_bits      <= pwdata[CARE_W-1:0];
        REG_PATTERN_LEN:  pattern_length <= pwdata[LEN_W-1:0];
        REG_REGION_BASE:  region_base    <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_LOW:  prdata = pattern_low;
      REG_PATTERN_HIGH: prdata = pattern_high;
      REG_CARE_BITS:    prdata = APB_DATA_W'(care_bits);
      REG_PATTERN_LEN:  prdata = APB_DATA_W'(pattern_length);
      REG_REGION_BASE:  prdata = region_base;
      default:          prdata = '0;
    endcase
  end

  // ---------------- Input stage ----------------
  // Stage moves on when it makes no result, or the result register is free or being drained.
  assign stage_advance = s_valid && (!res_valid || !out_valid || result_out.ready);
  assign byte_in.ready = !s_valid || stage_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      s_data <= byte_in.data_byte;
      s_last <= byte_in.last_byte;
    end
  end

  // ---------------- Window compare ----------------
  // Window after this byte: newest at index 0
  always_comb begin
    win_new[0] = s_data;
    for (int i = 1; i < PATTERN_BYTES; i++) begin
      win_new[i] = window[i-1];
    end
  end

  // Oversized lengths clamp to the window depth
  always_comb begin
    if (int'(pattern_length) > PATTERN_BYTES) begin
      len_eff = LEN_W'(PATTERN_BYTES);
    end else begin
      len_eff = pattern_length;
    end
  end

  // Position p (oldest first) sits at window index len-1-p
  always_comb begin
    logic [WIN_IDX_W-1:0] sel;
    win_match = 1'b1;
    for (int p = 0; p < PATTERN_BYTES; p++) begin
      sel = WIN_IDX_W'(int'(len_eff) - 1 - p);
      if (p < CARE_W && p < int'(len_eff) && care_bits[p % CARE_W]) begin
        if (win_new[sel] != pattern_byte(pattern_low, pattern_high, 4'(p))) begin
          win_match = 1'b0;
        end
      end
    end
  end

  // Enough bytes seen for the whole signature, counter not saturated
  assign can_check   = (count != COUNT_MAX);
  assign enough_seen = ({1'b0, count} + (COUNT_W+1)'(1)) >= (COUNT_W+1)'(len_eff);
  assign hit         = !reported && can_check && enough_seen && win_match;
  assign res_valid   = hit || (s_last && !reported);

  // Start offset: count+1-len, or count for an empty signature
  assign start_off = (len_eff == '0) ? count
                   : count + COUNT_W'(1) - COUNT_W'(len_eff);
  assign hit_addr  = region_base + ADDR_W'(start_off);

  // ---------------- Scan state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PATTERN_BYTES; i++) begin
        window[i] <= '0;
      end
      count    <= '0;
      reported <= 1'b0;
    end else if (stage_advance) begin
      if (s_last) begin
        for (int i = 0; i < PATTERN_BYTES; i++) begin
          window[i] <= '0;
        end
        count    <= '0;
        reported <= 1'b0;
      end else begin
        for (int i = 0; i < PATTERN_BYTES; i++) begin
          window[i] <= win_new[i];
        end
        if (can_check) begin
          count <= count + COUNT_W'(1);
        end
        reported <= reported || hit;
      end
    end
  end

  // ---------------- Result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance && res_valid) begin
      out_found <= hit;
      out_addr  <= hit ? hit_addr : '0;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.found         = out_found;
  assign result_out.match_address = out_addr;

  // ---------------- Assertions ----------------
  // Region end returns the scan state to the start of a region
  a_region_clear: assert property (@(posedge clk) disable iff (rst)
    stage_advance && s_last |=> (count == '0) && !reported)
    else $error("scan state not cleared after region end");

  // A result produced by the stage lands in the result register
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    stage_advance && res_valid |=> out_valid)
    else $error("result lost between stage and output");

  // Only one result per region: nothing more after a reported match
  a_one_per_region: assert property (@(posedge clk) disable iff (rst)
    stage_advance && reported |-> !res_valid)
    else $error("second result in one region");

  // A no-match result carries a zero address
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> out_addr == '0)
    else $error("no-match result with nonzero address");

endmodule

`default_nettype wire

/* sim/tb.sv */
// Testbench for the masked byte signature scan unit: directed and random regions, scoreboard.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbss_pkg::*;

  localparam int          RANDOM_ITEMS  = 1750;
  localparam int          SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 400_000;

  // One byte of the scanned region, plus a flag that holds it until results drain
  typedef struct packed {
    byte_t data;
    logic  last;
    logic  hold;
  } stream_byte_t;

  // One scan result
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Byte stream and result channels
  mbss_in_if  byte_ch ();
  mbss_out_if result_ch ();

  logic  in_valid  = 1'b0;
  byte_t in_data   = '0;
  logic  in_last   = 1'b0;
  logic  out_ready = 1'b0;

  assign byte_ch.valid     = in_valid;
  assign byte_ch.data_byte = in_data;
  assign byte_ch.last_byte = in_last;
  assign result_ch.ready   = out_ready;

  // APB port
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  masked_byte_signature_scan_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_ch),
    .result_out (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the registers
  logic [63:0]       cfg_lo   = '0;
  logic [63:0]       cfg_hi   = '0;
  logic [CARE_W-1:0] cfg_care = '0;
  logic [LEN_W-1:0]  cfg_len  = PATTERN_LEN_RESET;
  logic [ADDR_W-1:0] cfg_base = '0;

  // Scanner state: window newest first, byte offset, match already given
  byte_t              scan_win [PATTERN_BYTES];
  logic [COUNT_W-1:0] byte_cnt = '0;
  logic               hit_done = 1'b0;

  stream_byte_t pending_bytes [$];
  scan_hit_t    expected_hits [$];

  int          errors      = 0;
  int          items_sent  = 0;
  int unsigned cycle_count = 0;
  int          in_gap      = 0;
  int          out_gap     = 0;
  bit          quiet_phase = 1'b0;
  bit          in_taken    = 1'b0;
  bit          out_taken   = 1'b0;

  initial begin
    foreach (scan_win[i]) scan_win[i] = '0;
  end

  task automatic report_mismatch(input string what);
    if (errors < 100) $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic byte_t sig_byte(input int p);
    return (p < 8) ? cfg_lo[8*p +: 8] : cfg_hi[8*(p-8) +: 8];
  endfunction

  function automatic int eff_length();
    return (cfg_len > PATTERN_BYTES) ? PATTERN_BYTES : int'(cfg_len);
  endfunction

  function automatic int pick_gap();
    return quiet_phase ? 0 : $urandom_range(0, 10);
  endfunction

  // Advance the scanner by one byte; returns 1 when the byte yields a result
  function automatic bit scan_step(input byte_t d, input logic last, output scan_hit_t hit);
    int          i, p, len;
    logic [32:0] seen;
    bit          ok, emit;
    emit = 1'b0;
    hit  = '0;
    len  = eff_length();
    for (i = PATTERN_BYTES - 1; i > 0; i--) scan_win[i] = scan_win[i-1];
    scan_win[0] = d;
    // a saturated counter disables matching
    if (!hit_done && byte_cnt != COUNT_MAX) begin
      seen = {1'b0, byte_cnt} + 33'd1;
      if (seen >= 33'(len)) begin
        ok = 1'b1;
        for (p = 0; p < len; p++)
          if (p < CARE_W && cfg_care[p] && scan_win[len-1-p] != sig_byte(p)) ok = 1'b0;
        if (ok) begin
          hit.found = 1'b1;
          hit.addr  = cfg_base + ((len == 0) ? 64'(byte_cnt) : 64'(seen - 33'(len)));
          hit_done  = 1'b1;
          emit      = 1'b1;
        end
      end
    end
    if (byte_cnt != COUNT_MAX) byte_cnt++;
    // region end: report a miss, then start over
    if (last) begin
      if (!hit_done) begin
        hit  = '0;
        emit = 1'b1;
      end
      foreach (scan_win[i]) scan_win[i] = '0;
      byte_cnt = '0;
      hit_done = 1'b0;
    end
    return emit;
  endfunction

  // Register write: setup cycle, then access cycle
  task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:  cfg_lo   = val;
      REG_PATTERN_HIGH: cfg_hi   = val;
      REG_CARE_BITS:    cfg_care = val[CARE_W-1:0];
      REG_PATTERN_LEN:  cfg_len  = val[LEN_W-1:0];
      REG_REGION_BASE:  cfg_base = val;
      default: ;
    endcase
  endtask

  task automatic push_byte(input byte_t d, input logic last, input logic hold);
    pending_bytes.push_back('{data: d, last: last, hold: hold});
    items_sent++;
  endtask

  // Wait until the stream is empty and every result is in, then let the pipe settle
  task automatic drain();
    @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_hits.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random setting followed by regions of about budget bytes
  task automatic random_phase(input int budget);
    int          pushed, len, rlen, o, p, k, mode, nregions;
    bit          cut;
    byte_t       chunk [];
    logic [63:0] v;
    drain();
    quiet_phase = ($urandom_range(0, 3) == 0);
    reg_write(REG_PATTERN_LOW,  {$urandom, $urandom});
    reg_write(REG_PATTERN_HIGH, {$urandom, $urandom});
    case ($urandom_range(0, 3))
      0:       v = '0;
      1:       v = '1;
      default: v = {$urandom, $urandom};
    endcase
    reg_write(REG_CARE_BITS, v);
    case ($urandom_range(0, 7))
      0:       v = 64'd0;
      1:       v = 64'd16;
      2:       v = {$urandom, 27'd0, 5'($urandom_range(17, 31))};
      default: v = 64'($urandom_range(1, 16));
    endcase
    reg_write(REG_PATTERN_LEN, v);
    case ($urandom_range(0, 4))
      0:       v = '0;
      1:       v = '1;
      2:       v = {32'hFFFF_FFFF, $urandom};
      default: v = {$urandom, $urandom};
    endcase
    reg_write(REG_REGION_BASE, v);

    len      = eff_length();
    cut      = ($urandom_range(0, 3) == 0);
    pushed   = 0;
    nregions = 0;
    while (pushed < budget) begin
      rlen  = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 48) : $urandom_range(1, 20);
      chunk = new[rlen];
      // background mixes random bytes with signature bytes for near misses
      for (k = 0; k < rlen; k++)
        chunk[k] = $urandom_range(0, 1) ? byte_t'($urandom) : sig_byte($urandom_range(0, 15));
      mode = $urandom_range(0, 9);
      if (mode <= 5 && rlen >= len) begin
        o = $urandom_range(0, rlen - len);
        for (p = 0; p < len; p++)
          if (cfg_care[p]) chunk[o+p] = sig_byte(p);
        // spoil one position of the embedded signature
        if (mode == 5 && len > 0) begin
          p = $urandom_range(0, len - 1);
          chunk[o+p] = chunk[o+p] ^ byte_t'($urandom_range(1, 255));
        end
      end else if (mode <= 7 && len > 1) begin
        // signature cut off by the region end
        o = rlen - $urandom_range(1, len - 1);
        for (p = 0; p < len && o + p < rlen; p++)
          if (o + p >= 0 && cfg_care[p]) chunk[o+p] = sig_byte(p);
      end
      for (k = 0; k < rlen; k++)
        push_byte(chunk[k], (k == rlen - 1) && !(cut && pushed + rlen >= budget),
                  (nregions == 2) && (k == 0));
      pushed += rlen;
      nregions++;
    end
  endtask

  // Byte driver: random gap before each transfer, optional hold until results drain
  always @(negedge clk) begin : drive_bytes
    logic         next_valid;
    stream_byte_t head;
    next_valid = in_valid;
    if (in_valid && in_taken) next_valid = 1'b0;
    if (!next_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_bytes.size() != 0 &&
                   !(pending_bytes[0].hold && expected_hits.size() != 0)) begin
        head       = pending_bytes.pop_front();
        in_data   <= head.data;
        in_last   <= head.last;
        next_valid = 1'b1;
        in_gap     = pick_gap();
      end
    end
    in_valid <= next_valid;
  end

  // Result receiver: random stall after each transfer
  always @(negedge clk) begin : drive_ready
    if (out_taken) out_gap = pick_gap();
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check results, predict on each accepted byte, watch the cycle limit
  always @(posedge clk) begin : watch
    scan_hit_t want;
    scan_hit_t got;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      in_taken  = 1'b0;
      out_taken = 1'b0;
      if (!rst) begin
        if (result_ch.valid && out_ready) begin
          out_taken = 1'b1;
          if (expected_hits.size() == 0) begin
            report_mismatch($sformatf("unexpected result found=%0b addr=%h",
                                      result_ch.found, result_ch.match_address));
          end else begin
            want = expected_hits.pop_front();
            if (result_ch.found !== want.found)
              report_mismatch($sformatf("found %0b, want %0b", result_ch.found, want.found));
            if (result_ch.match_address !== want.addr)
              report_mismatch($sformatf("match_address %h, want %h",
                                        result_ch.match_address, want.addr));
          end
        end
        if (in_valid && byte_ch.ready) begin
          in_taken = 1'b1;
          if (scan_step(in_data, in_last, got)) expected_hits.push_back(got);
        end
      end
    end
  end

  initial begin : stimulus
    int k, first_random;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setting: one wildcard position matches the first byte; match on a last byte
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'h5A, 1'b1, 1'b0);

    // four positions 00 FF 00 FF, base at the top so the address wraps
    drain();
    reg_write(REG_PATTERN_LOW,  64'hA5A5_A5A5_FF00_FF00);
    reg_write(REG_PATTERN_HIGH, '1);
    reg_write(REG_CARE_BITS,    64'h0000_000F);
    reg_write(REG_PATTERN_LEN,  64'd4);
    reg_write(REG_REGION_BASE,  '1);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    // region ends inside a partial match: miss
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);

    // empty signature: matches at the first byte
    drain();
    reg_write(REG_PATTERN_LEN, 64'd0);
    reg_write(REG_REGION_BASE, 64'h0123_4567_89AB_CDEF);
    push_byte(8'h77, 1'b0, 1'b0);
    push_byte(8'h88, 1'b1, 1'b0);

    // oversized length clamps to sixteen, every position cared
    drain();
    reg_write(REG_PATTERN_LOW,  64'h0706_0504_0302_0100);
    reg_write(REG_PATTERN_HIGH, 64'h0F0E_0D0C_0B0A_0908);
    reg_write(REG_CARE_BITS,    '1);
    reg_write(REG_PATTERN_LEN,  '1);
    reg_write(REG_REGION_BASE,  64'h8000_0000_0000_0000);
    for (k = 0; k < 16; k++) push_byte(byte_t'(k), k == 15, 1'b0);

    // random settings and regions
    first_random = items_sent;
    while (items_sent - first_random < RANDOM_ITEMS) random_phase($urandom_range(40, 150));

    drain();
    if (expected_hits.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_hits.size()));
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* masked_byte_signature_scan_unit.f */
design/mbss_pkg.sv
design/mbss_in_if.sv
design/mbss_out_if.sv
design/masked_byte_signature_scan_unit.sv
sim/tb.sv
